>>> hw/rtl/sbs_pkg.sv
// Shared types and constants of the serial-bus block storage slave.
package sbs_pkg;

	localparam int unsigned BUFFER_BYTES_DEFAULT = 1024;

	localparam int unsigned S_TDATA_W = 8;
	localparam int unsigned S_TUSER_W = 2;
	localparam int unsigned M_TDATA_W = 32;

	// Byte address map seen by the host during the data phase.
	localparam logic [15:0] ADDR_BLOCK_LO = 16'h00FC;
	localparam logic [15:0] ADDR_BLOCK_HI = 16'h00FD;
	localparam logic [15:0] ADDR_COMMAND  = 16'h00FE;
	localparam logic [15:0] ADDR_ZERO     = 16'h00FF;
	localparam logic [5:0]  WINDOW_PAGE   = 6'b000001;

	localparam logic [7:0] BYTE_UNMAPPED = 8'hFF;
	localparam logic [7:0] BYTE_ZERO     = 8'h00;

	typedef enum logic [1:0] {
		OP_EXCHANGE = 2'd0,
		OP_SELECT   = 2'd1,
		OP_UNSELECT = 2'd2,
		OP_RESERVED = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_ADDR_LO = 2'd1,
		PH_ADDR_HI = 2'd2,
		PH_DATA    = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		REQ_NONE  = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_READ  = 2'd2
	} disk_req_t;

	// Buffer write issued by the protocol logic, by byte address.
	typedef struct packed {
		logic        en;
		logic [15:0] addr;
		logic [7:0]  data;
	} buf_wr_t;

	// Result fields produced for one request.
	typedef struct packed {
		logic [15:0] block_number;
		disk_req_t   disk_request;
		logic [7:0]  rx_byte;
	} result_t;

endpackage

>>> hw/rtl/sbs_ram.sv
// Generic single-port-write, registered-read RAM.
module sbs_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/sbs_ctrl.sv
// Protocol state, address decode and register file of the storage slave.
module sbs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  sbs_pkg::op_t      op,
	input  logic [7:0]        tx_byte,
	input  logic [7:0]        buf_rdata,
	output sbs_pkg::result_t  result,
	output sbs_pkg::buf_wr_t  buf_wr,
	output logic [15:0]       rd_addr
);

	import sbs_pkg::*;

	phase_t      phase_q, phase_d;
	logic [3:0]  left_q, left_d;
	logic [3:0]  cmd_xfer_q, cmd_xfer_d;
	logic [15:0] addr_q, addr_d;
	logic [15:0] block_q, block_d;
	logic [7:0]  cmd_reg_q, cmd_reg_d;
	logic [7:0]  last_rx_q, last_rx_d;
	logic [3:0]  left_dec;
	logic        in_window;
	logic [7:0]  read_byte;
	disk_req_t   req;

	assign left_dec  = left_q - 4'd1;
	assign in_window = (addr_q[15:10] == WINDOW_PAGE);

	always_comb begin
		priority if (in_window) begin
			read_byte = buf_rdata;
		end else if (addr_q == ADDR_BLOCK_LO) begin
			read_byte = block_q[7:0];
		end else if (addr_q == ADDR_BLOCK_HI) begin
			read_byte = block_q[15:8];
		end else if (addr_q == ADDR_COMMAND) begin
			read_byte = cmd_reg_q;
		end else if (addr_q == ADDR_ZERO) begin
			read_byte = BYTE_ZERO;
		end else begin
			read_byte = BYTE_UNMAPPED;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		left_d     = left_q;
		cmd_xfer_d = cmd_xfer_q;
		addr_d     = addr_q;
		block_d    = block_q;
		cmd_reg_d  = cmd_reg_q;
		last_rx_d  = last_rx_q;
		req        = REQ_NONE;
		buf_wr     = '{en: 1'b0, addr: addr_q, data: tx_byte};
		if (fire) begin
			unique case (op)
				OP_SELECT: begin
					addr_d = '0;
				end
				OP_UNSELECT: begin
					phase_d = PH_HEADER;
				end
				OP_EXCHANGE: begin
					unique case (phase_q)
						PH_HEADER: begin
							left_d     = tx_byte[3:0];
							cmd_xfer_d = tx_byte[7:4];
							phase_d    = PH_ADDR_LO;
						end
						PH_ADDR_LO: begin
							addr_d  = {8'h00, tx_byte};
							left_d  = left_dec;
							phase_d = (left_dec != 4'd0) ? PH_ADDR_HI : PH_DATA;
						end
						PH_ADDR_HI: begin
							addr_d  = {tx_byte, addr_q[7:0]};
							phase_d = PH_DATA;
						end
						PH_DATA: begin
							if (cmd_xfer_q[0]) begin
								last_rx_d = read_byte;
							end else begin
								priority if (in_window) begin
									buf_wr.en = 1'b1;
								end else if (addr_q == ADDR_BLOCK_LO) begin
									block_d = {block_q[15:8], tx_byte};
								end else if (addr_q == ADDR_BLOCK_HI) begin
									block_d = {tx_byte, block_q[7:0]};
								end else if (addr_q == ADDR_COMMAND) begin
									if (tx_byte == 8'(REQ_WRITE) || tx_byte == 8'(REQ_READ)) begin
										cmd_reg_d = '0;
										req       = disk_req_t'(tx_byte[1:0]);
									end else begin
										cmd_reg_d = tx_byte;
									end
								end else begin
									cmd_reg_d = cmd_reg_q;
								end
							end
							if (!cmd_xfer_q[1]) begin
								addr_d = addr_q + 16'd1;
							end
						end
						default: phase_d = PH_HEADER;
					endcase
				end
				OP_RESERVED: begin
					phase_d = phase_q;
				end
				default: phase_d = phase_q;
			endcase
		end
	end

	// The next request reads at the address this one leaves behind.
	assign rd_addr = addr_d;

	assign result = '{block_number: block_d, disk_request: req, rx_byte: last_rx_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			left_q     <= '0;
			cmd_xfer_q <= '0;
			addr_q     <= '0;
			block_q    <= '0;
			cmd_reg_q  <= '0;
			last_rx_q  <= '0;
		end else begin
			phase_q    <= phase_d;
			left_q     <= left_d;
			cmd_xfer_q <= cmd_xfer_d;
			addr_q     <= addr_d;
			block_q    <= block_d;
			cmd_reg_q  <= cmd_reg_d;
			last_rx_q  <= last_rx_d;
		end
	end

endmodule

>>> hw/rtl/spi_block_storage_slave_core.sv
// Top level of the serial-bus block storage slave: stage register, buffer and result register.
//
//  channel  | direction | payload                                   | handshake
//  ---------+-----------+-------------------------------------------+-----------------
//  s_*      | in        | tdata: tx_byte; tuser: op                 | tvalid / tready
//  m_*      | out       | tdata: rx_byte, disk_request, block_number | tvalid / tready
//
// Each request waits in the stage register until the result register is empty or being
// drained, and its result is then registered in the result register; one request is taken
// per cycle while the result is not stalled. The buffer's registered read port is why a
// request passes through the stage register: the read for a request is issued as it enters
// the stage register, at the address left by the request before.
// Reset clears the protocol state, register file and valid flags; stage and result data and buffer contents stay.
// A stalled result holds the stage, and the stage takes a new request only as it empties.
module spi_block_storage_slave_core #(
	parameter int unsigned BufferBytes = sbs_pkg::BUFFER_BYTES_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [sbs_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] tx_byte
	input  logic [sbs_pkg::S_TUSER_W-1:0] s_tuser,  // [1:0] op
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [sbs_pkg::M_TDATA_W-1:0] m_tdata   // [7:0] rx_byte, [9:8] disk_request,
	                                                 // [25:10] block_number, [31:26] zero
);

	import sbs_pkg::*;

	localparam int unsigned AW = $clog2(BufferBytes);

	// Window offset (low ten address bits) folded into the buffer depth. The offset
	// stays correct only while the offset is below four times the depth, as at most one of three subtractions applies.
	function automatic logic [AW-1:0] buf_idx(input logic [15:0] a);
		logic [11:0] w;
		w = {2'b00, a[9:0]};
		priority if (w >= 12'(3 * BufferBytes)) begin
			w = w - 12'(3 * BufferBytes);
		end else if (w >= 12'(2 * BufferBytes)) begin
			w = w - 12'(2 * BufferBytes);
		end else if (w >= 12'(BufferBytes)) begin
			w = w - 12'(BufferBytes);
		end else begin
			w = w;
		end
		return w[AW-1:0];
	endfunction

	// Stage register: the request being worked on.
	logic        valid_s1;
	op_t         op_s1;
	logic [7:0]  tx_s1;

	// Result register.
	logic        m_valid_q;
	result_t     result_q;

	// Forwarding of a buffer write to a read issued at the same edge.
	logic        byp_q;
	logic [7:0]  byp_data_q;

	logic        fire;
	logic        in_acc;
	result_t     result;
	buf_wr_t     buf_wr;
	logic [15:0] rd_addr;
	logic [AW-1:0] wr_idx;
	logic [AW-1:0] rd_idx;
	logic [7:0]  ram_rdata;
	logic [7:0]  buf_rdata;

	// The stage moves on when the result register is empty or being drained.
	assign fire     = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || fire;
	assign in_acc   = s_tvalid && s_tready;

	assign wr_idx    = buf_idx(buf_wr.addr);
	assign rd_idx    = buf_idx(rd_addr);
	assign buf_rdata = byp_q ? byp_data_q : ram_rdata;

	sbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.op        (op_s1),
		.tx_byte   (tx_s1),
		.buf_rdata (buf_rdata),
		.result    (result),
		.buf_wr    (buf_wr),
		.rd_addr   (rd_addr)
	);

	sbs_ram #(
		.Width (8),
		.Depth (BufferBytes)
	) u_buf (
		.clk   (clk),
		.we    (buf_wr.en),
		.waddr (wr_idx),
		.wdata (buf_wr.data),
		.re    (in_acc),
		.raddr (rd_idx),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
			byp_q     <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
				// A write retiring at this edge is not yet visible to the RAM read.
				byp_q    <= buf_wr.en && (wr_idx == rd_idx);
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1      <= op_t'(s_tuser);
			tx_s1      <= s_tdata;
			byp_data_q <= buf_wr.data;
		end
		if (fire) begin
			result_q <= result;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'b000000, result_q.block_number, result_q.disk_request,
		result_q.rx_byte};

endmodule
